// ----- hdl/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// fts_pkg
// Shared codes and types for the FIFO task scheduler with sleep list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

  // operation codes on func
  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_YIELD = 3'd1;
  localparam logic [2:0] FN_SLEEP = 3'd2;
  localparam logic [2:0] FN_EXIT  = 3'd3;
  localparam logic [2:0] FN_ADD   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_POP,
    ST_POP_WAIT,
    ST_SP_RD,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic tick;
    logic append;
  } sleep_req_t;

endpackage : fts_pkg

`default_nettype wire

// ----- hdl/fts_ready_fifo.sv -----
// ----------------------------------------------------------------------------
// fts_ready_fifo
// Circular FIFO of ready task ids in a synchronous RAM; pop data in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fts_ready_fifo import fts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  localparam int IDX_W = $clog2(MAX_TASKS)
) (
  input  logic             clk,
  input  logic             rst,
  input  fifo_req_t        req,
  input  logic [IDX_W-1:0] push_id,
  output logic [IDX_W-1:0] pop_id,
  output logic             empty
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [IDX_W-1:0] mem [MAX_TASKS];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0]   tail_sum;
  logic             do_push;
  logic             do_pop;

  assign tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  // head + count stays below twice the depth: one compare and subtract wraps it
  assign tail = (tail_sum >= (CNT_W+1)'(MAX_TASKS)) ?
                IDX_W'(tail_sum - (CNT_W+1)'(MAX_TASKS)) : IDX_W'(tail_sum);
  assign head_inc = (head == IDX_W'(MAX_TASKS - 1)) ? '0 : head + 1'b1;

  assign do_push = req.push && (count != CNT_W'(MAX_TASKS));
  assign do_pop  = req.pop && (count != '0);
  assign empty   = (count == '0);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_id;
    end
    if (do_pop) begin
      pop_id <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (do_pop) begin
        head <= head_inc;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule : fts_ready_fifo

`default_nettype wire

// ----- hdl/fts_sleep_list.sv -----
// ----------------------------------------------------------------------------
// fts_sleep_list
// Compact list of sleeping tasks in a synchronous RAM. A tick walks the list
// one entry per cycle, decrements, compacts in place and emits expired ids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fts_sleep_list import fts_pkg::*; #(
  parameter int MAX_TASKS   = 16,
  parameter int DELAY_WIDTH = 16,
  localparam int IDX_W = $clog2(MAX_TASKS),
  localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sleep_req_t             req,
  input  logic [IDX_W-1:0]       append_id,
  input  logic [DELAY_WIDTH-1:0] append_delay,
  output logic                   push_valid,
  output logic [IDX_W-1:0]       push_id,
  output logic                   done,
  output logic [CNT_W-1:0]       woken
);

  typedef struct packed {
    logic [IDX_W-1:0]       id;
    logic [DELAY_WIDTH-1:0] left;
  } entry_t;

  entry_t                 mem [MAX_TASKS];
  entry_t                 rd;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       rd_idx;
  logic [CNT_W-1:0]       kept;
  logic                   walking;
  logic                   pipe_vld;
  logic                   issue;
  logic                   finish;
  logic                   keep;
  logic                   do_append;
  logic [DELAY_WIDTH-1:0] left_dec;

  assign issue     = walking && (rd_idx < count);
  assign finish    = walking && !issue && !pipe_vld;
  assign left_dec  = rd.left - 1'b1;
  assign keep      = pipe_vld && (left_dec != '0);
  assign push_valid = pipe_vld && (left_dec == '0);
  assign push_id   = rd.id;
  assign do_append = req.append && (count != CNT_W'(MAX_TASKS));

  // writes land at kept <= index already read, so no read-ahead is disturbed
  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[count[IDX_W-1:0]] <= {append_id, append_delay};
    end else if (keep) begin
      mem[kept[IDX_W-1:0]] <= {rd.id, left_dec};
    end
    if (issue) begin
      rd <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_idx   <= '0;
      kept     <= '0;
      woken    <= '0;
      walking  <= 1'b0;
      pipe_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= finish;
      if (req.tick) begin
        walking  <= 1'b1;
        rd_idx   <= '0;
        kept     <= '0;
        woken    <= '0;
        pipe_vld <= 1'b0;
      end else if (walking) begin
        pipe_vld <= issue;
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (keep) begin
          kept <= kept + 1'b1;
        end
        if (push_valid) begin
          woken <= woken + 1'b1;
        end
        if (finish) begin
          walking <= 1'b0;
          count   <= kept;
        end
      end
      if (do_append) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule : fts_sleep_list

`default_nettype wire

// ----- hdl/fifo_task_scheduler_with_delays_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_task_scheduler_with_delays_unit
// Task scheduler: ready FIFO, sleep list, saved stack pointers, running task.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func, task_id, delay_ms, saved_sp and raise start;
//   the item is taken at a clock edge with start high and busy low. busy stays
//   high until the result has been shown.
//   Result channel: done is high for exactly one cycle while run_task, run_sp,
//   first_run, woken_count and error hold the result of that item. The
//   receiver cannot stall; it must take the result in that cycle.
//   One item is in work at a time. The tick walk over the sleep list RAM
//   (one entry per cycle) sets the worst case. Every step ends with a read of
//   the stack pointer RAM for the running task.
//   Reset (rst, synchronous) empties the ready FIFO and sleep list, leaves
//   only the idle task 0 live and running. The stack pointer of a task is
//   defined once that task has been added or has saved one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fifo_task_scheduler_with_delays_unit import fts_pkg::*; #(
  parameter int MAX_TASKS   = 16,
  parameter int SP_WIDTH    = 16,
  parameter int DELAY_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [3:0]  task_id,
  input  logic [15:0] delay_ms,
  input  logic [15:0] saved_sp,
  output logic        done,
  output logic [3:0]  run_task,
  output logic [15:0] run_sp,
  output logic        first_run,
  output logic [4:0]  woken_count,
  output logic        error
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  state_t state, state_next;

  logic [2:0]             func_q;
  logic [3:0]             task_id_q;
  logic [DELAY_WIDTH-1:0] delay_q;
  logic [SP_WIDTH-1:0]    sp_q;
  logic [IDX_W-1:0]       running;
  logic [MAX_TASKS-1:0]   live;
  logic                   pop_hit;
  logic                   moved;
  logic                   err;

  logic [SP_WIDTH-1:0]    sp_mem [MAX_TASKS];
  logic [SP_WIDTH-1:0]    sp_rd;
  logic                   sp_we;
  logic [IDX_W-1:0]       sp_waddr;
  logic [SP_WIDTH-1:0]    sp_wdata;
  logic                   sp_re;

  logic [IDX_W-1:0]       add_idx;
  logic                   cur_idle;
  logic                   add_bad;
  logic                   err_now;
  logic                   moved_now;
  logic                   live_set;
  logic                   live_clr;
  logic                   accept;

  fifo_req_t              fifo_req;
  logic [IDX_W-1:0]       fifo_push_id;
  logic [IDX_W-1:0]       fifo_pop_id;
  logic                   fifo_empty;

  sleep_req_t             slp_req;
  logic [DELAY_WIDTH-1:0] slp_delay;
  logic                   slp_push;
  logic [IDX_W-1:0]       slp_push_id;
  logic                   slp_done;
  logic [CNT_W-1:0]       slp_woken;

  fts_ready_fifo #(
    .MAX_TASKS (MAX_TASKS)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .req     (fifo_req),
    .push_id (fifo_push_id),
    .pop_id  (fifo_pop_id),
    .empty   (fifo_empty)
  );

  fts_sleep_list #(
    .MAX_TASKS   (MAX_TASKS),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_sleep (
    .clk          (clk),
    .rst          (rst),
    .req          (slp_req),
    .append_id    (running),
    .append_delay (slp_delay),
    .push_valid   (slp_push),
    .push_id      (slp_push_id),
    .done         (slp_done),
    .woken        (slp_woken)
  );

  assign accept    = start && (state == ST_IDLE);
  assign cur_idle  = (running == '0);
  assign add_idx   = IDX_W'(task_id_q);
  assign add_bad   = (task_id_q == 4'd0) || (int'(task_id_q) >= MAX_TASKS) || live[add_idx];
  // sleep of zero ticks would wrap on the first decrement
  assign slp_delay = (delay_q == '0) ? DELAY_WIDTH'(1) : delay_q;

  always_comb begin
    err_now   = 1'b0;
    moved_now = 1'b0;
    case (func_q)
      FN_YIELD, FN_SLEEP: moved_now = 1'b1;
      FN_EXIT: begin
        err_now   = cur_idle;
        moved_now = !cur_idle;
      end
      FN_ADD:  err_now = add_bad;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (func == FN_TICK) ? ST_TICK : ST_EXEC;
        end
      end
      ST_EXEC:     state_next = moved_now ? ST_POP : ST_SP_RD;
      ST_TICK:     state_next = slp_done ? ST_SP_RD : ST_TICK;
      ST_POP:      state_next = ST_POP_WAIT;
      ST_POP_WAIT: state_next = ST_SP_RD;
      ST_SP_RD:    state_next = ST_RESULT;
      ST_RESULT:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state != ST_IDLE);
    done           = 1'b0;
    fifo_req       = '0;
    fifo_push_id   = running;
    slp_req        = '0;
    sp_we          = 1'b0;
    sp_waddr       = running;
    sp_wdata       = sp_q;
    sp_re          = 1'b0;
    live_set       = 1'b0;
    live_clr       = 1'b0;
    case (state)
      ST_IDLE: slp_req.tick = start && (func == FN_TICK);
      ST_EXEC: begin
        case (func_q)
          FN_YIELD: begin
            sp_we         = 1'b1;
            fifo_req.push = !cur_idle;
          end
          FN_SLEEP: begin
            sp_we          = 1'b1;
            slp_req.append = !cur_idle;
          end
          FN_EXIT: live_clr = !cur_idle;
          FN_ADD: begin
            if (!add_bad) begin
              live_set      = 1'b1;
              sp_we         = 1'b1;
              sp_waddr      = add_idx;
              sp_wdata      = '0;
              fifo_req.push = 1'b1;
              fifo_push_id  = add_idx;
            end
          end
          default: ;
        endcase
      end
      ST_TICK: begin
        fifo_req.push = slp_push;
        fifo_push_id  = slp_push_id;
      end
      ST_POP:      fifo_req.pop = 1'b1;
      ST_POP_WAIT: ;
      ST_SP_RD:    sp_re = 1'b1;
      ST_RESULT:   done = 1'b1;
      default: ;
    endcase
  end

  // stack pointer RAM: write and read never fall in the same cycle
  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[sp_waddr] <= sp_wdata;
    end
    if (sp_re) begin
      sp_rd <= sp_mem[running];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= func;
      task_id_q <= task_id;
      delay_q   <= DELAY_WIDTH'(delay_ms);
      sp_q      <= SP_WIDTH'(saved_sp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      running <= '0;
      live    <= MAX_TASKS'(1);
      pop_hit <= 1'b0;
      moved   <= 1'b0;
      err     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        moved <= 1'b0;
        err   <= 1'b0;
      end
      if (state == ST_EXEC) begin
        moved <= moved_now;
        err   <= err_now;
      end
      if (live_set) begin
        live[add_idx] <= 1'b1;
      end
      if (live_clr) begin
        live[running] <= 1'b0;
      end
      if (state == ST_POP) begin
        pop_hit <= !fifo_empty;
      end
      if (state == ST_POP_WAIT) begin
        running <= pop_hit ? fifo_pop_id : '0;
      end
    end
  end

  assign run_task    = 4'(running);
  assign run_sp      = 16'(sp_rd);
  assign first_run   = moved && (sp_rd == '0);
  assign woken_count = (func_q == FN_TICK) ? 5'(slp_woken) : 5'd0;
  assign error       = err;

endmodule : fifo_task_scheduler_with_delays_unit

`default_nettype wire

// ----- hdl/fts_checker.sv -----
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks for the task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic       first_run,
  input wire logic [4:0] woken_count,
  input wire logic       error
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after item accept");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown with no item in work");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result");

  // dispatch never coincides with an error or a tick wake-up report
  a_first_run_excl: assert property (@(posedge clk) disable iff (rst)
    done && (error || (woken_count != 5'd0)) |-> !first_run)
    else $error("first_run together with error or wake count");

endmodule : fts_checker

bind fifo_task_scheduler_with_delays_unit fts_checker u_fts_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .first_run   (first_run),
  .woken_count (woken_count),
  .error       (error)
);

`default_nettype wire
